FILE: rtl/mbet_pkg.sv
// Shared types and constants of the Mandelbrot escape-time pixel block.
package mbet_pkg;

    localparam int MAX_DIM   = 1024;
    localparam int FRAC_BITS = 28;

    localparam int COORD_W = $clog2(MAX_DIM);
    localparam int CFG_W   = 32;
    localparam int STEP_W  = 31;
    localparam int ITER_W  = 16;
    localparam int SHADE_W = 8;
    localparam int MUL_W   = 32;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int Z_W     = 45;
    localparam int SQ_W    = 32;
    localparam int QUO_W   = ITER_W + SHADE_W;
    localparam int CNT_W   = $clog2(QUO_W + 1);

    localparam logic signed [Z_W-1:0] TWO     = Z_W'(2) << FRAC_BITS;
    localparam logic signed [Z_W-1:0] NEG_TWO = -TWO;
    localparam logic [SQ_W:0]         FOUR    = (SQ_W + 1)'(4) << FRAC_BITS;

    localparam logic [CFG_W-1:0] X_ORIGIN_RST   = 32'hDE00_0000;
    localparam logic [CFG_W-1:0] Y_ORIGIN_RST   = 32'hE800_0000;
    localparam logic [STEP_W-1:0] STEP_RST      = 31'd1006633;
    localparam logic [ITER_W-1:0] MAX_ITER_RST  = 16'd1024;

    typedef enum logic [1:0] {
        REG_X_ORIGIN   = 2'd0,
        REG_Y_ORIGIN   = 2'd1,
        REG_PIXEL_STEP = 2'd2,
        REG_MAX_ITER   = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CRE,
        ST_CIM,
        ST_INIT,
        ST_CHECK,
        ST_MBB,
        ST_MAB,
        ST_UPD,
        ST_DIV,
        ST_DIVW,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic             start;
        logic [ITER_W-1:0] divisor;
    } div_ctl_t;

endpackage

FILE: rtl/mbet_mult.sv
// Shared signed multiplier with registered product.
module mbet_mult
(
    input  logic                                  clk,
    input  logic signed [mbet_pkg::MUL_W-1:0]     op_a,
    input  logic signed [mbet_pkg::MUL_W-1:0]     op_b,
    output logic signed [mbet_pkg::PROD_W-1:0]    product
);

    logic signed [mbet_pkg::PROD_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= op_a * op_b;
    end

    assign product = product_reg;

endmodule

FILE: rtl/mbet_div.sv
// Restoring divider, one quotient bit per cycle.
module mbet_div
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  mbet_pkg::div_ctl_t               ctl,
    input  logic [mbet_pkg::QUO_W-1:0]       dividend,
    output logic [mbet_pkg::QUO_W-1:0]       quotient,
    output logic                             done
);

    logic [mbet_pkg::QUO_W-1:0]  quo_reg, quo_next;
    logic [mbet_pkg::ITER_W-1:0] rem_reg, rem_next;
    logic [mbet_pkg::ITER_W-1:0] dsr_reg, dsr_next;
    logic [mbet_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [mbet_pkg::ITER_W:0]   shifted;
    logic [mbet_pkg::ITER_W:0]   diff;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[mbet_pkg::QUO_W-1]};
        diff      = shifted - {1'b0, dsr_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = ctl.divisor;
            cnt_next  = mbet_pkg::CNT_W'(mbet_pkg::QUO_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[mbet_pkg::ITER_W])
            begin
                rem_next = diff[mbet_pkg::ITER_W-1:0];
                quo_next = {quo_reg[mbet_pkg::QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[mbet_pkg::ITER_W-1:0];
                quo_next = {quo_reg[mbet_pkg::QUO_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == mbet_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

FILE: rtl/mandelbrot_escape_time_pixel.sv
// Top level: sequencer and datapath of the Mandelbrot escape-time pixel.
//
// Input stream: one beat per pixel, tdata carries col and row. Output stream:
// one beat per pixel with shade, iteration count and escape flag.
// Registers x_origin, y_origin, pixel_step and max_iter are to be written through
// cfg_we / cfg_index / cfg_data while the block is idle; the block does not enforce it.
//
// A pixel is taken in the idle state. Forming c takes the CRE, CIM and INIT states,
// each iteration the CHECK, MBB, MAB and UPD states on the one shared 32x32
// multiplier (a*a, b*b, a*b, update). A last CHECK ends the loop on the bound or
// limit, or UPD ends it when |z|^2 > 4; then come the shade division and loading
// of the output register. The next pixel is taken in the idle state after the
// result is loaded; the iteration count k (at most max_iter) and the multiplier
// set the rate.
//
// Reset clears the sequencer, the output valid flag and loads the default
// view (-2.125, -1.5, step about 3/800, limit 1024). A stalled receiver holds
// the result in the output register; the next pixel is still taken and
// iterated, and waits at its end until the register is free.
module mandelbrot_escape_time_pixel
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // col[9:0], row[19:10], zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // shade[7:0], iter_count[23:8], escaped[24], zero fill
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int ZW = mbet_pkg::Z_W;
    localparam int CW = mbet_pkg::COORD_W;
    localparam int IW = mbet_pkg::ITER_W;
    localparam int SW = mbet_pkg::SQ_W;
    localparam int FB = mbet_pkg::FRAC_BITS;

    mbet_pkg::state_t state_reg, state_next;

    logic signed [31:0]                 x_origin_reg;
    logic signed [31:0]                 y_origin_reg;
    logic [mbet_pkg::STEP_W-1:0]        step_reg;
    logic [IW-1:0]                      max_iter_reg;

    logic [CW-1:0]                      col_reg, col_next;
    logic [CW-1:0]                      row_reg, row_next;
    logic signed [ZW-1:0]               c_re_reg, c_re_next;
    logic signed [ZW-1:0]               c_im_reg, c_im_next;
    logic signed [ZW-1:0]               a_reg, a_next;
    logic signed [ZW-1:0]               b_reg, b_next;
    logic [SW-1:0]                      a2_reg, a2_next;
    logic [SW-1:0]                      b2_reg, b2_next;
    logic [IW-1:0]                      k_reg, k_next;
    logic                               esc_reg, esc_next;

    logic                               out_valid_reg, out_valid_next;
    logic [mbet_pkg::SHADE_W-1:0]       shade_reg, shade_next;
    logic [IW-1:0]                      iter_reg, iter_next;
    logic                               oesc_reg, oesc_next;

    logic signed [mbet_pkg::MUL_W-1:0]  op_a, op_b;
    logic signed [mbet_pkg::PROD_W-1:0] product;
    logic signed [mbet_pkg::PROD_W-1:0] ab_sh;
    logic [SW:0]                        mag;
    logic                               out_free;
    logic                               guard_hit;
    logic                               limit_hit;
    logic                               mag_hit;
    mbet_pkg::div_ctl_t                 div_ctl;
    logic [mbet_pkg::QUO_W-1:0]         div_quo;
    logic                               div_done;

    mbet_mult u_mult
    (
        .clk     (clk),
        .op_a    (op_a),
        .op_b    (op_b),
        .product (product)
    );

    mbet_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend ({k_reg, 8'b0} - {8'b0, k_reg}),
        .quotient (div_quo),
        .done     (div_done)
    );

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign guard_hit = (a_reg > mbet_pkg::TWO) || (a_reg < mbet_pkg::NEG_TWO)
                    || (b_reg > mbet_pkg::TWO) || (b_reg < mbet_pkg::NEG_TWO);
    assign limit_hit = (k_reg == max_iter_reg);
    assign mag       = {1'b0, a2_reg} + {1'b0, b2_reg};
    assign mag_hit   = (mag > mbet_pkg::FOUR);
    assign ab_sh     = product >>> (FB - 1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mbet_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = mbet_pkg::ST_CRE;
                end
            end
            mbet_pkg::ST_CRE:   state_next = mbet_pkg::ST_CIM;
            mbet_pkg::ST_CIM:   state_next = mbet_pkg::ST_INIT;
            mbet_pkg::ST_INIT:  state_next = mbet_pkg::ST_CHECK;
            mbet_pkg::ST_CHECK:
            begin
                if (limit_hit || guard_hit)
                begin
                    state_next = mbet_pkg::ST_DIV;
                end
                else
                begin
                    state_next = mbet_pkg::ST_MBB;
                end
            end
            mbet_pkg::ST_MBB:   state_next = mbet_pkg::ST_MAB;
            mbet_pkg::ST_MAB:   state_next = mbet_pkg::ST_UPD;
            mbet_pkg::ST_UPD:
            begin
                if (mag_hit)
                begin
                    state_next = mbet_pkg::ST_DIV;
                end
                else
                begin
                    state_next = mbet_pkg::ST_CHECK;
                end
            end
            mbet_pkg::ST_DIV:   state_next = mbet_pkg::ST_DIVW;
            mbet_pkg::ST_DIVW:
            begin
                if (div_done)
                begin
                    state_next = mbet_pkg::ST_FIN;
                end
            end
            mbet_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = mbet_pkg::ST_IDLE;
                end
            end
            default:            state_next = mbet_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready   = (state_reg == mbet_pkg::ST_IDLE);
        op_a            = a_reg[31:0];
        op_b            = a_reg[31:0];
        div_ctl.start   = 1'b0;
        div_ctl.divisor = max_iter_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        c_re_next       = c_re_reg;
        c_im_next       = c_im_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        a2_next         = a2_reg;
        b2_next         = b2_reg;
        k_next          = k_reg;
        esc_next        = esc_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        shade_next      = shade_reg;
        iter_next       = iter_reg;
        oesc_next       = oesc_reg;
        unique case (state_reg)
            mbet_pkg::ST_IDLE:
            begin
                col_next = s_axis_tdata[CW-1:0];
                row_next = s_axis_tdata[2*CW-1:CW];
            end
            mbet_pkg::ST_CRE:
            begin
                op_a = {1'b0, step_reg};
                op_b = {{(mbet_pkg::MUL_W-CW){1'b0}}, col_reg};
            end
            mbet_pkg::ST_CIM:
            begin
                c_re_next = {{(ZW-32){x_origin_reg[31]}}, x_origin_reg} + product[ZW-1:0];
                op_a      = {1'b0, step_reg};
                op_b      = {{(mbet_pkg::MUL_W-CW){1'b0}}, row_reg};
            end
            mbet_pkg::ST_INIT:
            begin
                c_im_next = {{(ZW-32){y_origin_reg[31]}}, y_origin_reg} + product[ZW-1:0];
                a_next    = c_re_reg;
                b_next    = c_im_next;
                k_next    = '0;
                esc_next  = 1'b0;
            end
            mbet_pkg::ST_CHECK:
            begin
                if (!limit_hit && guard_hit)
                begin
                    esc_next = 1'b1;
                end
            end
            mbet_pkg::ST_MBB:
            begin
                a2_next = product[FB+SW-1:FB];
                op_a    = b_reg[31:0];
                op_b    = b_reg[31:0];
            end
            mbet_pkg::ST_MAB:
            begin
                b2_next = product[FB+SW-1:FB];
                op_a    = a_reg[31:0];
                op_b    = b_reg[31:0];
            end
            mbet_pkg::ST_UPD:
            begin
                if (mag_hit)
                begin
                    esc_next = 1'b1;
                end
                else
                begin
                    b_next = ab_sh[ZW-1:0] + c_im_reg;
                    a_next = {{(ZW-SW){1'b0}}, a2_reg} - {{(ZW-SW){1'b0}}, b2_reg}
                           + c_re_reg;
                    k_next = k_reg + 1'b1;
                end
            end
            mbet_pkg::ST_DIV:
            begin
                div_ctl.start = 1'b1;
            end
            mbet_pkg::ST_DIVW:
            begin
            end
            mbet_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    iter_next      = k_reg;
                    oesc_next      = esc_reg;
                    if (max_iter_reg == '0)
                    begin
                        shade_next = 8'hFF;
                    end
                    else
                    begin
                        shade_next = 8'hFF - div_quo[mbet_pkg::SHADE_W-1:0];
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mbet_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            esc_reg       <= 1'b0;
            x_origin_reg  <= mbet_pkg::X_ORIGIN_RST;
            y_origin_reg  <= mbet_pkg::Y_ORIGIN_RST;
            step_reg      <= mbet_pkg::STEP_RST;
            max_iter_reg  <= mbet_pkg::MAX_ITER_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
            esc_reg       <= esc_next;
            if (cfg_we)
            begin
                unique case (mbet_pkg::cfg_reg_t'(cfg_index))
                    mbet_pkg::REG_X_ORIGIN:   x_origin_reg <= cfg_data;
                    mbet_pkg::REG_Y_ORIGIN:   y_origin_reg <= cfg_data;
                    mbet_pkg::REG_PIXEL_STEP: step_reg     <= cfg_data[mbet_pkg::STEP_W-1:0];
                    mbet_pkg::REG_MAX_ITER:   max_iter_reg <= cfg_data[IW-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg   <= col_next;
        row_reg   <= row_next;
        c_re_reg  <= c_re_next;
        c_im_reg  <= c_im_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        a2_reg    <= a2_next;
        b2_reg    <= b2_next;
        shade_reg <= shade_next;
        iter_reg  <= iter_next;
        oesc_reg  <= oesc_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, oesc_reg, iter_reg, shade_reg};

`ifndef ASSERT_OFF
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == mbet_pkg::ST_CRE))
        else $error("accepted pixel did not start the sequence");

    a_fin_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mbet_pkg::ST_FIN && out_free) |=> out_valid_reg)
        else $error("finished pixel not placed in output register");

    a_div_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == mbet_pkg::ST_DIVW))
        else $error("divider finished while sequencer not waiting");

    a_k_only_in_loop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != mbet_pkg::ST_INIT && state_reg != mbet_pkg::ST_UPD) |=> $stable(k_reg))
        else $error("iteration count changed outside the loop");
`endif

endmodule
